// File: hw/rtl/hdgs_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// hdgs_pkg - heat diffusion grid step shared definitions
// Grid geometry, Q1.15 cell format, arithmetic widths and command codes.
// ============================================================================
package hdgs_pkg;

    // Grid geometry
    localparam int MAX_WIDTH  = 256;
    localparam int MAX_HEIGHT = 256;
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int ROW_W      = $clog2(MAX_HEIGHT);
    localparam int XCNT_W     = $clog2(MAX_WIDTH + 1);
    localparam int YCNT_W     = $clog2(MAX_HEIGHT + 1);
    localparam int ADDR_W     = COL_W + ROW_W;
    localparam int LB_AW      = COL_W + 1;

    // Port field widths
    localparam int DIM_W   = 9;
    localparam int POS_W   = 8;
    localparam int OP_W    = 2;
    localparam int CFG_IDX_W = 2;

    // Q1.15 cell format and datapath widths
    localparam int FIELD_W = 16;
    localparam int FRAC_W  = 15;
    localparam int SUM_W   = FIELD_W + 4;
    localparam int PROD_W  = SUM_W + FIELD_W;
    localparam int V_W     = PROD_W + 2;
    localparam int Q_MAX   = 2 ** (FIELD_W - 1) - 1;
    localparam int Q_MIN   = -(2 ** (FIELD_W - 1));
    localparam int ROUND_HALF = 2 ** (FRAC_W - 1);

    typedef logic signed [FIELD_W-1:0] t_cell;
    typedef logic [OP_W-1:0]           t_opcode;
    typedef logic [CFG_IDX_W-1:0]      t_cfg_idx;
    typedef logic [DIM_W-1:0]          t_dim;
    typedef logic [POS_W-1:0]          t_pos;

    localparam t_cell CELL_MIN = {1'b1, {(FIELD_W-1){1'b0}}};

    // Command codes
    localparam t_opcode OP_WRITE = 2'd0;
    localparam t_opcode OP_READ  = 2'd1;
    localparam t_opcode OP_STEP  = 2'd2;

    // Configuration register indexes
    localparam t_cfg_idx REG_GRID_WIDTH  = 2'd0;
    localparam t_cfg_idx REG_GRID_HEIGHT = 2'd1;

endpackage

// File: hw/rtl/heat_diffusion_grid_step.sv
`timescale 1ns / 1ps
// ============================================================================
// heat_diffusion_grid_step - Q1.15 temperature grid with Jacobi diffusion
// Holds the grid in one synchronous memory; a step streams every cell through
// a five-point Laplacian pipeline with a two-row line buffer of old values.
// ============================================================================
//
//  channel   handshake                      payload
//  -------   -----------------------------  -----------------------------------
//  command   start / busy                   i_opcode i_col i_row i_cell_value
//                                           i_transfer_coeff i_ambient_change
//  result    o_valid (one-cycle strobe)     o_read_value o_status
//  config    i_cfg_valid / o_cfg_ready      i_cfg_index i_cfg_data
//
//  Write and rejected commands: result in the following cycle, busy stays
//  low. Read: result registered in the S_READ state. Step: one cell per cycle
//  through the single memory write port, plus one slot per row for the
//  right-hand neighbor and a drain of the update pipeline at the end.
//  Reset clears control state and the grid size; grid contents stay undefined
//  until written. The receiver cannot stall; each result is a one-cycle strobe.
//
module heat_diffusion_grid_step (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      start,
    output logic                      busy,
    input  hdgs_pkg::t_opcode         i_opcode,
    input  hdgs_pkg::t_pos            i_col,
    input  hdgs_pkg::t_pos            i_row,
    input  hdgs_pkg::t_cell           i_cell_value,
    input  hdgs_pkg::t_cell           i_transfer_coeff,
    input  hdgs_pkg::t_cell           i_ambient_change,
    output logic                      o_valid,
    output hdgs_pkg::t_cell           o_read_value,
    output logic                      o_status,
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  hdgs_pkg::t_cfg_idx        i_cfg_index,
    input  hdgs_pkg::t_dim            i_cfg_data
);
    import hdgs_pkg::*;

    typedef enum logic [1:0] {S_IDLE, S_READ, S_STEP, S_DRAIN} t_state;

    // Control and result registers
    t_state                r_state;
    logic                  r_valid;
    t_cell                 r_read_value;
    logic                  r_status;
    t_dim                  r_grid_width;
    t_dim                  r_grid_height;
    t_cell                 r_coeff;
    t_cell                 r_ambient;
    logic [XCNT_W-1:0]     r_j;
    logic [ROW_W-1:0]      r_y;

    // Memories and their read data
    t_cell                 r_cell_store [0:MAX_WIDTH*MAX_HEIGHT-1];
    t_cell                 r_prev_rows  [0:2*MAX_WIDTH-1];
    t_cell                 r_rd_a;
    t_cell                 r_rd_b;
    t_cell                 r_rd_l;

    // Pipeline registers
    logic                  r_t1_v;
    logic [XCNT_W-1:0]     r_t1_j;
    logic [ROW_W-1:0]      r_t1_y;
    logic                  r_t1_top;
    logic                  r_t1_bot;
    t_cell                 r_left;
    t_cell                 r_mid;
    t_cell                 r_up;
    t_cell                 r_down;
    logic                  r_t2_v;
    logic [ADDR_W-1:0]     r_t2_addr;
    logic                  r_t2_border;
    logic signed [SUM_W-1:0]  r_t2_diff;
    t_cell                 r_t2_c;
    logic                  r_t3_v;
    logic [ADDR_W-1:0]     r_t3_addr;
    logic                  r_t3_border;
    logic signed [PROD_W-1:0] r_t3_prod;
    t_cell                 r_t3_c;
    logic                  r_t4_v;
    logic [ADDR_W-1:0]     r_t4_addr;
    t_cell                 r_t4_data;

    // Combinational signals
    logic [XCNT_W-1:0]     eff_w;
    logic [YCNT_W-1:0]     eff_h;
    logic                  in_range;
    logic [ADDR_W-1:0]     cmd_addr;
    logic [ADDR_W-1:0]     rd_addr_a;
    logic [ADDR_W-1:0]     rd_addr_b;
    logic                  cs_we;
    logic [ADDR_W-1:0]     cs_waddr;
    t_cell                 cs_wdata;
    logic                  lb_we;
    logic [LB_AW-1:0]      lb_waddr;
    logic [LB_AW-1:0]      lb_raddr;
    logic                  row_last;
    logic                  pipe_empty;
    logic signed [SUM_W-1:0]  n_diff;
    logic                  n_border;
    logic signed [V_W-1:0] n_sum;
    logic signed [V_W-1:0] n_q;
    t_cell                 n_cell;

    // Clamp the grid size to the memory geometry
    always_comb begin
        eff_w = (32'(r_grid_width) > MAX_WIDTH) ? XCNT_W'(MAX_WIDTH)
                                                : XCNT_W'(r_grid_width);
        eff_h = (32'(r_grid_height) > MAX_HEIGHT) ? YCNT_W'(MAX_HEIGHT)
                                                  : YCNT_W'(r_grid_height);
    end

    // Decode the command address
    assign in_range = (32'(i_col) < 32'(eff_w)) && (32'(i_row) < 32'(eff_h));
    assign cmd_addr = {ROW_W'(i_row), COL_W'(i_col)};
    assign row_last = ((YCNT_W'(r_y) + YCNT_W'(1)) == eff_h);
    assign pipe_empty = !(r_t1_v || r_t2_v || r_t3_v || r_t4_v);

    // Steer the memory ports
    assign rd_addr_a = (r_state == S_STEP) ? {r_y, COL_W'(r_j)} : cmd_addr;
    assign rd_addr_b = {ROW_W'(r_y + ROW_W'(1)), COL_W'(r_j)};
    assign lb_raddr  = {~r_y[0], COL_W'(r_j)};
    assign lb_waddr  = {r_t1_y[0], COL_W'(r_t1_j)};
    assign lb_we     = r_t1_v && (r_t1_j < eff_w);

    always_comb begin
        cs_we    = r_t4_v;
        cs_waddr = r_t4_addr;
        cs_wdata = r_t4_data;
        if (!r_t4_v && r_state == S_IDLE && start && i_opcode == OP_WRITE && in_range) begin
            cs_we    = 1'b1;
            cs_waddr = cmd_addr;
            cs_wdata = i_cell_value;
        end
    end

    // Grid memory: one write port, two read ports
    always_ff @(posedge i_clk) begin
        if (cs_we) begin
            r_cell_store[cs_waddr] <= cs_wdata;
        end
        r_rd_a <= r_cell_store[rd_addr_a];
        r_rd_b <= r_cell_store[rd_addr_b];
    end

    // Line buffer of pre-step rows, two banks by row parity
    always_ff @(posedge i_clk) begin
        if (lb_we) begin
            r_prev_rows[lb_waddr] <= r_rd_a;
        end
        r_rd_l <= r_prev_rows[lb_raddr];
    end

    // Configuration registers
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_width  <= '0;
            r_grid_height <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                REG_GRID_WIDTH:  r_grid_width  <= i_cfg_data;
                REG_GRID_HEIGHT: r_grid_height <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Laplacian for the column behind the one just read
    always_comb begin
        n_diff = SUM_W'(r_left) + SUM_W'(r_rd_a) + SUM_W'(r_up) + SUM_W'(r_down)
               - (SUM_W'(r_mid) <<< 2);
        n_border = r_t1_top || r_t1_bot || (r_t1_j == XCNT_W'(1)) || (r_t1_j >= eff_w);
    end

    // Scale, offset, round half up and saturate; border cells get the minimum
    always_comb begin
        n_sum = (V_W'(r_t3_c) <<< FRAC_W) + V_W'(r_t3_prod)
              + (V_W'(r_ambient) <<< FRAC_W) + V_W'(ROUND_HALF);
        n_q   = n_sum >>> FRAC_W;
        if (r_t3_border) begin
            n_cell = CELL_MIN;
        end else if (n_q > V_W'(Q_MAX)) begin
            n_cell = t_cell'(Q_MAX);
        end else if (n_q < V_W'(Q_MIN)) begin
            n_cell = CELL_MIN;
        end else begin
            n_cell = n_q[FIELD_W-1:0];
        end
    end

    // Update pipeline
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_t1_v <= 1'b0;
            r_t2_v <= 1'b0;
            r_t3_v <= 1'b0;
            r_t4_v <= 1'b0;
        end else begin
            // issue tag for the reads launched this cycle
            r_t1_v   <= (r_state == S_STEP);
            r_t1_j   <= r_j;
            r_t1_y   <= r_y;
            r_t1_top <= (r_y == '0);
            r_t1_bot <= ((YCNT_W'(r_y) + YCNT_W'(1)) >= eff_h);

            // advance the neighbor window
            if (r_t1_v) begin
                r_left <= r_mid;
                r_mid  <= r_rd_a;
                r_up   <= r_rd_l;
                r_down <= r_rd_b;
            end

            r_t2_v      <= r_t1_v && (r_t1_j != '0);
            r_t2_addr   <= {r_t1_y, COL_W'(r_t1_j - XCNT_W'(1))};
            r_t2_border <= n_border;
            r_t2_diff   <= n_diff;
            r_t2_c      <= r_mid;

            // 20 by 16 bit signed product, sign-extended to the product width
            r_t3_v      <= r_t2_v;
            r_t3_addr   <= r_t2_addr;
            r_t3_border <= r_t2_border;
            r_t3_prod   <= PROD_W'(r_t2_diff) * PROD_W'(r_coeff);
            r_t3_c      <= r_t2_c;

            r_t4_v      <= r_t3_v;
            r_t4_addr   <= r_t3_addr;
            r_t4_data   <= n_cell;
        end
    end

    // Command sequencer and result registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_valid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (start) begin
                        r_read_value <= '0;
                        case (i_opcode)
                            OP_WRITE: begin
                                r_valid  <= 1'b1;
                                r_status <= !in_range;
                            end
                            OP_READ: begin
                                if (in_range) begin
                                    r_state <= S_READ;
                                end else begin
                                    r_valid  <= 1'b1;
                                    r_status <= 1'b1;
                                end
                            end
                            OP_STEP: begin
                                if (eff_w == '0 || eff_h == '0) begin
                                    r_valid  <= 1'b1;
                                    r_status <= 1'b1;
                                end else begin
                                    r_coeff   <= i_transfer_coeff;
                                    r_ambient <= i_ambient_change;
                                    r_j       <= '0;
                                    r_y       <= '0;
                                    r_state   <= S_STEP;
                                end
                            end
                            default: begin
                                r_valid  <= 1'b1;
                                r_status <= 1'b1;
                            end
                        endcase
                    end
                end
                S_READ: begin
                    r_valid      <= 1'b1;
                    r_status     <= 1'b0;
                    r_read_value <= r_rd_a;
                    r_state      <= S_IDLE;
                end
                S_STEP: begin
                    // one column slot past the edge feeds the last right neighbor
                    if (r_j == eff_w) begin
                        r_j <= '0;
                        if (row_last) begin
                            r_state <= S_DRAIN;
                        end else begin
                            r_y <= r_y + ROW_W'(1);
                        end
                    end else begin
                        r_j <= r_j + XCNT_W'(1);
                    end
                end
                S_DRAIN: begin
                    if (pipe_empty) begin
                        r_valid  <= 1'b1;
                        r_status <= 1'b0;
                        r_state  <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign busy         = (r_state != S_IDLE);
    assign o_valid      = r_valid;
    assign o_read_value = r_read_value;
    assign o_status     = r_status;

`ifndef SYNTHESIS
    a_result_has_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start || busy))
        else $error("result strobe without a transaction in flight");

    a_pipe_write_in_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_t4_v |-> (r_state == S_STEP || r_state == S_DRAIN))
        else $error("update write outside a step");

    a_step_done_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && $past(r_state == S_DRAIN)) |-> pipe_empty)
        else $error("step reported done with writes pending");

    a_column_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_STEP) |-> (r_j <= eff_w))
        else $error("column counter beyond grid width");
`endif

endmodule
